[design/assert_macros.svh]
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/ubds_pkg.sv]
// shared types and constants of the baud divisor search
package ubds_pkg;
	localparam int unsigned MAX_RATIO = 32;
	localparam int unsigned MIN_RATIO = 4;
	localparam int unsigned EDGE_MAX_RATIO = 8;
	localparam int unsigned CLK_MIN_KHZ = 32;
	localparam int unsigned CLK_MAX_KHZ = 50000;
	localparam int unsigned CLK_RESET_KHZ = 48000;
	localparam int unsigned RECIP_100 = 5368710;
	localparam int unsigned RECIP_SHIFT = 29;
	localparam int unsigned DIV_STEPS = 13;

	localparam int unsigned KHZ_W = 16;
	localparam int unsigned BAUD_W = 22;
	localparam int unsigned CLK_W = 26;
	localparam int unsigned DEN_W = 27;
	localparam int unsigned RATIO_W = 6;
	localparam int unsigned DIVISOR_W = 13;
	localparam int unsigned THR_W = 18;
	localparam int unsigned IN_DATA_W = 24;
	localparam int unsigned OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_BAD_CLK = 2'd1,
		STATUS_BAD_BAUD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_BAD_CLK = 2'd0,
		KIND_ZERO_BAUD = 2'd1,
		KIND_SEARCH = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [BAUD_W-1:0] baud;
		logic [CLK_W-1:0] clk_hz;
		logic [THR_W-1:0] thr;
	} entry_t;

	typedef struct packed {
		logic start;
		logic [CLK_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [CLK_W-1:0] quo;
	} div_rsp_t;
endpackage

[design/ubds_front.sv]
// front stage: takes a request, classifies it and precomputes clock and error limit
module ubds_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ubds_pkg::BAUD_W-1:0] in_baud,
	input  logic [ubds_pkg::KHZ_W-1:0] cfg_khz,
	output logic out_valid,
	input  logic out_ready,
	output ubds_pkg::entry_t out_entry
);
	import ubds_pkg::*;

	logic valid_s1;
	entry_t entry_s1;
	logic [BAUD_W+24-1:0] prod;
	logic [15:0] quot;
	kind_t kind;

	assign prod = {24'd0, in_baud} * (BAUD_W+24)'(RECIP_100);
	assign quot = prod[RECIP_SHIFT +: 16];

	always_comb begin
		if (cfg_khz > KHZ_W'(CLK_MAX_KHZ) || cfg_khz < KHZ_W'(CLK_MIN_KHZ)) begin
			kind = KIND_BAD_CLK;
		end else if (in_baud == '0) begin
			kind = KIND_ZERO_BAUD;
		end else begin
			kind = KIND_SEARCH;
		end
	end

	assign in_ready = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1.kind <= kind;
			entry_s1.baud <= in_baud;
			entry_s1.clk_hz <= CLK_W'(cfg_khz) * CLK_W'(10'd1000);
			entry_s1.thr <= {2'b00, quot} + {1'b0, quot, 1'b0};
		end
	end
endmodule

[design/ubds_fifo.sv]
// two-entry queue between front and back
module ubds_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ubds_pkg::entry_t push_entry,
	output logic full,
	input  logic pop,
	output logic empty,
	output ubds_pkg::entry_t pop_entry
);
	import ubds_pkg::*;

	entry_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end
endmodule

[design/ubds_div.sv]
// shared restoring divider, two quotient bits per cycle
module ubds_div (
	input  logic clk,
	input  logic arst_n,
	input  ubds_pkg::div_req_t req,
	output ubds_pkg::div_rsp_t rsp
);
	import ubds_pkg::*;

	logic busy_q;
	logic done_q;
	logic [3:0] cnt_q;
	logic [CLK_W-1:0] num_q;
	logic [CLK_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] r1;
	logic [DEN_W:0] r2;
	logic [DEN_W-1:0] r1b;
	logic [DEN_W-1:0] r2b;
	logic q1;
	logic q2;

	always_comb begin
		r1 = {rem_q, num_q[CLK_W-1]};
		q1 = r1 >= {1'b0, den_q};
		r1b = q1 ? DEN_W'(r1 - {1'b0, den_q}) : DEN_W'(r1);
		r2 = {r1b, num_q[CLK_W-2]};
		q2 = r2 >= {1'b0, den_q};
		r2b = q2 ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && cnt_q == 4'd1;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[CLK_W-3:0], 2'b00};
			rem_q <= r2b;
			quo_q <= {quo_q[CLK_W-3:0], q1, q2};
		end
	end
endmodule

[design/ubds_back.sv]
// back stage: ratio search over the shared divider and the result register
module ubds_back (
	input  logic clk,
	input  logic arst_n,
	input  logic fifo_empty,
	output logic fifo_pop,
	input  ubds_pkg::entry_t fifo_entry,
	output logic out_valid,
	input  logic out_ready,
	output logic [ubds_pkg::OUT_DATA_W-1:0] out_data
);
	import ubds_pkg::*;

	typedef enum logic [5:0] {
		BK_IDLE   = 6'b000001,
		BK_LOAD_D = 6'b000010,
		BK_WAIT_D = 6'b000100,
		BK_LOAD_A = 6'b001000,
		BK_WAIT_A = 6'b010000,
		BK_FIN    = 6'b100000
	} bk_state_t;

	bk_state_t state_q;
	entry_t ent_q;
	logic [RATIO_W-1:0] r_q;
	logic [CLK_W-1:0] d_q;
	logic found_q;
	logic [CLK_W-1:0] best_err_q;
	logic [RATIO_W-1:0] best_r_q;
	logic [CLK_W-1:0] best_d_q;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [CLK_W-1:0] baud_ext;
	logic [CLK_W-1:0] err;
	logic last_r;
	logic out_free;
	logic fin_fire;
	logic ok;
	status_t status;
	logic [OUT_DATA_W-1:0] result;

	ubds_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	assign baud_ext = CLK_W'(ent_q.baud);
	assign err = drsp.quo > baud_ext ? drsp.quo - baud_ext : baud_ext - drsp.quo;
	assign last_r = r_q == RATIO_W'(MAX_RATIO);
	assign out_free = !out_valid_q || out_ready;
	assign fin_fire = state_q == BK_FIN && out_free;
	assign fifo_pop = state_q == BK_IDLE && !fifo_empty;
	assign ok = found_q && best_err_q < CLK_W'(ent_q.thr);

	always_comb begin
		dreq.start = state_q == BK_LOAD_D || state_q == BK_LOAD_A;
		dreq.num = ent_q.clk_hz;
		if (state_q == BK_LOAD_A) begin
			dreq.den = DEN_W'(r_q) * DEN_W'(d_q);
		end else begin
			dreq.den = DEN_W'(ent_q.baud) * DEN_W'(r_q);
		end
	end

	always_comb begin
		case (ent_q.kind)
			KIND_BAD_CLK: status = STATUS_BAD_CLK;
			KIND_ZERO_BAUD: status = STATUS_BAD_BAUD;
			default: status = ok ? STATUS_OK : STATUS_BAD_BAUD;
		endcase
		if (status == STATUS_OK) begin
			result = {2'b00, best_r_q <= RATIO_W'(EDGE_MAX_RATIO),
				best_d_q[DIVISOR_W-1:0], best_r_q, status};
		end else begin
			result = {22'd0, status};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (!fifo_empty) begin
						state_q <= fifo_entry.kind == KIND_SEARCH ? BK_LOAD_D : BK_FIN;
					end
				end
				BK_LOAD_D: state_q <= BK_WAIT_D;
				BK_WAIT_D: begin
					if (drsp.done) begin
						if (drsp.quo != '0) begin
							state_q <= BK_LOAD_A;
						end else begin
							state_q <= last_r ? BK_FIN : BK_LOAD_D;
						end
					end
				end
				BK_LOAD_A: state_q <= BK_WAIT_A;
				BK_WAIT_A: begin
					if (drsp.done) begin
						state_q <= last_r ? BK_FIN : BK_LOAD_D;
					end
				end
				BK_FIN: begin
					if (out_free) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				ent_q <= fifo_entry;
				r_q <= RATIO_W'(MIN_RATIO);
				found_q <= 1'b0;
			end
			BK_WAIT_D: begin
				if (drsp.done) begin
					d_q <= drsp.quo;
					if (drsp.quo == '0 && !last_r) begin
						r_q <= r_q + RATIO_W'(1);
					end
				end
			end
			BK_WAIT_A: begin
				if (drsp.done) begin
					if (!found_q || err <= best_err_q) begin
						found_q <= 1'b1;
						best_err_q <= err;
						best_r_q <= r_q;
						best_d_q <= d_q;
					end
					if (!last_r) begin
						r_q <= r_q + RATIO_W'(1);
					end
				end
			end
			BK_FIN: begin
				if (out_free) begin
					out_data_q <= result;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[design/uart_baud_divisor_search_unit.sv]
// top level of the uart baud divisor search
// a bad clock or zero baud skips the search; a search tries each of the 29 ratios with one
// division on the shared divider, and a second one when the first gives a nonzero divisor
// the back stage takes a new request only once the result of the last one is registered
// the front and a two-entry queue keep taking requests while the search runs
// reset: asynchronous, active low; clock register returns to 48000 khz, queues empty
module uart_baud_divisor_search_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [ubds_pkg::IN_DATA_W-1:0] s_tdata,   // requested_baud[21:0]
	output logic m_tvalid,
	input  logic m_tready,
	// status[1:0], oversample_ratio[7:2], baud_divisor[20:8], both_edge_sampling[21]
	output logic [ubds_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [ubds_pkg::KHZ_W-1:0] cfg_wdata
);
	import ubds_pkg::*;
	`include "assert_macros.svh"

	logic [KHZ_W-1:0] khz_q;
	logic front_valid;
	logic fifo_full;
	logic fifo_empty;
	logic fifo_pop;
	entry_t front_entry;
	entry_t fifo_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			khz_q <= KHZ_W'(CLK_RESET_KHZ);
		end else if (cfg_we) begin
			khz_q <= cfg_wdata;
		end
	end

	ubds_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_baud(s_tdata[BAUD_W-1:0]),
		.cfg_khz(khz_q),
		.out_valid(front_valid),
		.out_ready(!fifo_full),
		.out_entry(front_entry)
	);

	ubds_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_valid && !fifo_full),
		.push_entry(front_entry),
		.full(fifo_full),
		.pop(fifo_pop),
		.empty(fifo_empty),
		.pop_entry(fifo_entry)
	);

	ubds_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fifo_empty(fifo_empty),
		.fifo_pop(fifo_pop),
		.fifo_entry(fifo_entry),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

	`ASSERT_NEXT(a_accept_fills_front, s_tvalid && s_tready, front_valid)
	`ASSERT_SAME(a_no_pop_when_empty, fifo_empty, !fifo_pop)
	`ASSERT_SAME(a_ratio_in_range, m_tvalid && m_tdata[1:0] == STATUS_OK,
		m_tdata[7:2] >= RATIO_W'(MIN_RATIO) && m_tdata[7:2] <= RATIO_W'(MAX_RATIO))
	`ASSERT_SAME(a_error_fields_zero, m_tvalid && m_tdata[1:0] != STATUS_OK,
		m_tdata[21:2] == '0)
endmodule
